// ===== hdl/bcf_pkg.sv =====
// Shared types, constants and microcode for the biquad cascade filter.
// No dependencies; every other file of the block imports this package.
package bcf_pkg;

   // Default datapath widths (top-level parameters take these)
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int STATE_WIDTH_DEF = 32;

   // Fixed field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int NUM_REG_W  = 48;
   localparam int DEN_REG_W  = 32;
   localparam int SHIFT_W    = 3;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int UPC_W      = 4;

   // Register reset values
   localparam logic [NUM_REG_W-1:0] NUM1_RST   = 48'd70368744194048;
   localparam logic [DEN_REG_W-1:0] DEN1_RST   = 32'd268489407;
   localparam logic [NUM_REG_W-1:0] NUM2_RST   = 48'd1073758208;
   localparam logic [DEN_REG_W-1:0] DEN2_RST   = 32'd268447041;
   localparam logic                 STRUCT_RST = 1'b1;
   localparam logic [SHIFT_W-1:0]   SHIFT_RST  = 3'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM1   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRUCT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT  = 3'd5;

   // Micro-op kinds
   localparam logic [1:0] UK_NOP  = 2'd0;
   localparam logic [1:0] UK_LOAD = 2'd1;  // acc <= operand
   localparam logic [1:0] UK_MAC  = 2'd2;  // multiply, accumulate in the next cycle
   localparam logic [1:0] UK_SAT  = 2'd3;  // saturate sum, write destination

   // Coefficient selects
   localparam logic [2:0] CS_B0 = 3'd0;
   localparam logic [2:0] CS_B1 = 3'd1;
   localparam logic [2:0] CS_B2 = 3'd2;
   localparam logic [2:0] CS_A1 = 3'd3;
   localparam logic [2:0] CS_A2 = 3'd4;

   // Operand selects
   localparam logic [1:0] OS_X  = 2'd0;
   localparam logic [1:0] OS_T  = 2'd1;
   localparam logic [1:0] OS_D0 = 2'd2;
   localparam logic [1:0] OS_D1 = 2'd3;

   // Saturated-result destinations
   localparam logic [1:0] DS_T      = 2'd0;  // temp word (v or y)
   localparam logic [1:0] DS_D0     = 2'd1;  // first delay word
   localparam logic [1:0] DS_XSHIFT = 2'd2;  // DF2 end: x <= y, shift delays in
   localparam logic [1:0] DS_D1X    = 2'd3;  // TDF2 end: d1 <= sum, x <= y

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] coef;
      logic [1:0] opnd;
      logic       neg;
      logic [1:0] dest;
      logic       init_d1;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    run;
      logic    sec;
      logic    fin;
      uop_type uop;
   } ctl_type;

   typedef struct packed {
      logic [NUM_REG_W-1:0] num1;
      logic [DEN_REG_W-1:0] den1;
      logic [NUM_REG_W-1:0] num2;
      logic [DEN_REG_W-1:0] den2;
      logic                 tdf;
      logic [SHIFT_W-1:0]   shift;
   } cfg_type;

   function automatic uop_type bcf_mk(input logic [1:0] kind, input logic [2:0] coef,
                                      input logic [1:0] opnd, input logic neg,
                                      input logic [1:0] dest, input logic init_d1,
                                      input logic last);
      uop_type u;
      u.kind    = kind;
      u.coef    = coef;
      u.opnd    = opnd;
      u.neg     = neg;
      u.dest    = dest;
      u.init_d1 = init_d1;
      u.last    = last;
      return u;
   endfunction

   // Per-section program: DF2 takes 8 steps, TDF2 takes 9
   function automatic uop_type bcf_uop(input logic tdf, input logic [UPC_W-1:0] pc);
      uop_type u;
      u = bcf_mk(UK_NOP, CS_B0, OS_X, 1'b0, DS_T, 1'b0, 1'b0);
      unique case ({tdf, pc})
         // direct form II: v = x - a1 d0 - a2 d1 ; y = b0 v + b1 d0 + b2 d1
         {1'b0, 4'd0}: u = bcf_mk(UK_LOAD, CS_B0, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd1}: u = bcf_mk(UK_MAC,  CS_A1, OS_D0, 1'b1, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd2}: u = bcf_mk(UK_MAC,  CS_A2, OS_D1, 1'b1, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd3}: u = bcf_mk(UK_SAT,  CS_B0, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd4}: u = bcf_mk(UK_MAC,  CS_B0, OS_T,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd5}: u = bcf_mk(UK_MAC,  CS_B1, OS_D0, 1'b0, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd6}: u = bcf_mk(UK_MAC,  CS_B2, OS_D1, 1'b0, DS_T,      1'b0, 1'b0);
         {1'b0, 4'd7}: u = bcf_mk(UK_SAT,  CS_B0, OS_X,  1'b0, DS_XSHIFT, 1'b0, 1'b1);
         // transposed DF II: y = b0 x + d0 ; d0 = b1 x - a1 y + d1 ; d1 = b2 x - a2 y
         {1'b1, 4'd0}: u = bcf_mk(UK_LOAD, CS_B0, OS_D0, 1'b0, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd1}: u = bcf_mk(UK_MAC,  CS_B0, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd2}: u = bcf_mk(UK_SAT,  CS_B0, OS_X,  1'b0, DS_T,      1'b1, 1'b0);
         {1'b1, 4'd3}: u = bcf_mk(UK_MAC,  CS_B1, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd4}: u = bcf_mk(UK_MAC,  CS_A1, OS_T,  1'b1, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd5}: u = bcf_mk(UK_SAT,  CS_B0, OS_X,  1'b0, DS_D0,     1'b0, 1'b0);
         {1'b1, 4'd6}: u = bcf_mk(UK_MAC,  CS_B2, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd7}: u = bcf_mk(UK_MAC,  CS_A2, OS_T,  1'b1, DS_T,      1'b0, 1'b0);
         {1'b1, 4'd8}: u = bcf_mk(UK_SAT,  CS_B0, OS_X,  1'b0, DS_D1X,    1'b0, 1'b1);
         default:      u = bcf_mk(UK_NOP,  CS_B0, OS_X,  1'b0, DS_T,      1'b0, 1'b0);
      endcase
      return u;
   endfunction

endpackage

// ===== hdl/bcf_if.sv =====
// Handshake channels of the biquad cascade filter: sample in, result out, register writes.
// Depends on bcf_pkg for field widths.
interface bcf_req_if import bcf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bcf_rsp_if import bcf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface bcf_csr_if import bcf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bcf_csr_regs.sv =====
// Configuration registers of the biquad cascade filter.
// Depends on bcf_pkg and the bcf_csr_if channel.
module bcf_csr_regs import bcf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bcf_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // Decode a write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_NUM1:   cfg_in.num1  = csr_bus.data[NUM_REG_W-1:0];
            CSR_DEN1:   cfg_in.den1  = csr_bus.data[DEN_REG_W-1:0];
            CSR_NUM2:   cfg_in.num2  = csr_bus.data[NUM_REG_W-1:0];
            CSR_DEN2:   cfg_in.den2  = csr_bus.data[DEN_REG_W-1:0];
            CSR_STRUCT: cfg_in.tdf   = csr_bus.data[0];
            CSR_SHIFT:  cfg_in.shift = csr_bus.data[SHIFT_W-1:0];
            default:    cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num1  <= NUM1_RST;
         cfg_ff.den1  <= DEN1_RST;
         cfg_ff.num2  <= NUM2_RST;
         cfg_ff.den2  <= DEN2_RST;
         cfg_ff.tdf   <= STRUCT_RST;
         cfg_ff.shift <= SHIFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/bcf_mac_unit.sv =====
// Shared multiply-accumulate unit: one registered multiplier, rounding,
// accumulator and saturation to the state width. Depends on bcf_pkg.
module bcf_mac_unit import bcf_pkg::*; #(
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run,
   input  uop_type                       uop,
   input  logic signed [COEF_WIDTH-1:0]  coef,
   input  logic signed [STATE_WIDTH-1:0] opnd,
   input  logic signed [STATE_WIDTH-1:0] init_val,
   output logic signed [STATE_WIDTH-1:0] sat_val,
   output logic                          sat_clip
);

   localparam int PW = COEF_WIDTH + STATE_WIDTH;   // exact product
   localparam int RW = STATE_WIDTH + 2;            // rounded product
   localparam int AW = STATE_WIDTH + 4;            // accumulator
   localparam int HW = AW - STATE_WIDTH + 1;       // bits checked for overflow
   localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (COEF_WIDTH - 3);

   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 pend_ff, pend_in;
   logic                 neg_ff, neg_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] rnd_full;
   logic signed [RW-1:0] rnd;
   logic signed [AW-1:0] contrib;
   logic signed [AW-1:0] sum;
   logic [HW-1:0]        sum_hi;

   // Round the product held from last cycle and fold it into the sum
   always_comb begin
      rnd_full = prod_ff + RND_HALF;
      rnd      = rnd_full[PW-1:COEF_WIDTH-2];
      contrib  = '0;
      if (pend_ff) begin
         contrib = neg_ff ? -AW'(rnd) : AW'(rnd);
      end
      sum    = acc_ff + contrib;
      sum_hi = sum[AW-1:STATE_WIDTH-1];
   end

   // Saturate to the state range
   always_comb begin
      if ((&sum_hi) || !(|sum_hi)) begin
         sat_val  = sum[STATE_WIDTH-1:0];
         sat_clip = 1'b0;
      end else begin
         sat_val  = {sum[AW-1], {(STATE_WIDTH-1){~sum[AW-1]}}};
         sat_clip = 1'b1;
      end
   end

   // Step the unit by the current micro-op
   always_comb begin
      prod_in = prod_ff;
      pend_in = pend_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      if (run) begin
         unique case (uop.kind)
            UK_LOAD: begin
               acc_in  = AW'(opnd);
               pend_in = 1'b0;
            end
            UK_MAC: begin
               prod_in = coef * opnd;
               pend_in = 1'b1;
               neg_in  = uop.neg;
               acc_in  = sum;
            end
            UK_SAT: begin
               acc_in  = AW'(init_val);
               pend_in = 1'b0;
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
   end

endmodule

// ===== hdl/bcf_sequencer.sv =====
// Sequencer of the biquad cascade filter: accepts an item, steps the
// section microcode twice, then finishes the result. Depends on bcf_pkg.
module bcf_sequencer import bcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    out_free,
   input  logic    tdf,
   output logic    ready,
   output ctl_type ctl
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   logic             sec_ff, sec_in;
   uop_type          uop;

   assign uop   = bcf_uop(tdf, pc_ff);
   assign ready = (state_ff == ST_IDLE);

   always_comb begin
      ctl.load = (state_ff == ST_IDLE) && req_valid;
      ctl.run  = (state_ff == ST_RUN);
      ctl.sec  = sec_ff;
      ctl.fin  = (state_ff == ST_FINAL) && out_free;
      ctl.uop  = uop;
   end

   // Advance through both sections, hold at the end until the output slot frees
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      sec_in   = sec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               pc_in    = '0;
               sec_in   = 1'b0;
            end
         end
         ST_RUN: begin
            if (uop.last) begin
               pc_in = '0;
               if (sec_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  sec_in = 1'b1;
               end
            end else begin
               pc_in = pc_ff + UPC_W'(1);
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         sec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sec_ff   <= sec_in;
      end
   end

endmodule

// ===== hdl/biquad_cascade_filter.sv =====
// Two-section biquad IIR cascade (DF II or transposed DF II) on one shared MAC.
// Depends on bcf_pkg, bcf_if, bcf_csr_regs, bcf_mac_unit and bcf_sequencer.
//
// Usage:
//   req_bus carries one signed Q1.15 sample per item; rsp_bus returns one
//   filtered, shifted and saturated sample per item with a clip flag that is
//   set when any delay word, section output or the final output saturated.
//   csr_bus writes the six registers (index 0..5); it is always ready. The user
//   must write it only while the block is idle; the block does not enforce this.
// Operation:
//   The block takes one item at a time. Both sections run on one shared
//   16x32 multiplier under a microcode sequencer: 8 steps per section in
//   direct form II, 9 in transposed form, plus one finishing step that
//   registers the result; the next item is accepted only once the
//   sequencer is back in idle after that step.
// Stalls and reset:
//   The result sits in an output register; a new item is accepted while it
//   waits, and the finishing step holds until that register is taken.
//   Reset restores the register defaults and clears all four delay words.
module biquad_cascade_filter import bcf_pkg::*; #(
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bcf_req_if.sink    req_bus,
   bcf_rsp_if.source  rsp_bus,
   bcf_csr_if.sink    csr_bus
);

   localparam int NUM_EXT_W = (3 * COEF_WIDTH > NUM_REG_W) ? 3 * COEF_WIDTH : NUM_REG_W;
   localparam int DEN_EXT_W = (2 * COEF_WIDTH > DEN_REG_W) ? 2 * COEF_WIDTH : DEN_REG_W;
   localparam int OHW       = STATE_WIDTH - SAMPLE_W + 1;

   cfg_type cfg;
   ctl_type ctl;
   logic    seq_ready;
   logic    out_free;

   logic signed [STATE_WIDTH-1:0] x_ff, x_in;
   logic signed [STATE_WIDTH-1:0] t_ff, t_in;
   logic signed [STATE_WIDTH-1:0] cur0_ff, cur0_in, cur1_ff, cur1_in;
   logic signed [STATE_WIDTH-1:0] oth0_ff, oth0_in, oth1_ff, oth1_in;
   logic                          clip_ff, clip_in;
   logic signed [SAMPLE_W-1:0]    out_ff, out_in;
   logic                          outclip_ff, outclip_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [NUM_EXT_W-1:0]          num_ext;
   logic [DEN_EXT_W-1:0]          den_ext;
   logic signed [COEF_WIDTH-1:0]  coef;
   logic signed [STATE_WIDTH-1:0] opnd;
   logic signed [STATE_WIDTH-1:0] init_val;
   logic signed [STATE_WIDTH-1:0] sat_val;
   logic                          sat_clip;
   logic signed [STATE_WIDTH-1:0] shifted;
   logic [OHW-1:0]                shifted_hi;
   logic signed [SAMPLE_W-1:0]    final_val;
   logic                          final_clip;
   logic                          do_sat;

   bcf_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bcf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .out_free  (out_free),
      .tdf       (cfg.tdf),
      .ready     (seq_ready),
      .ctl       (ctl)
   );

   bcf_mac_unit #(
      .COEF_WIDTH  (COEF_WIDTH),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .run      (ctl.run),
      .uop      (ctl.uop),
      .coef     (coef),
      .opnd     (opnd),
      .init_val (init_val),
      .sat_val  (sat_val),
      .sat_clip (sat_clip)
   );

   assign req_bus.ready      = seq_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = out_ff;
   assign rsp_bus.clipped    = outclip_ff;
   assign out_free           = !rsp_valid_ff || rsp_bus.ready;
   assign do_sat             = ctl.run && (ctl.uop.kind == UK_SAT);

   // Pick the running section's coefficient; fields past the register read as zero
   always_comb begin
      num_ext = ctl.sec ? NUM_EXT_W'(cfg.num2) : NUM_EXT_W'(cfg.num1);
      den_ext = ctl.sec ? DEN_EXT_W'(cfg.den2) : DEN_EXT_W'(cfg.den1);
      case (ctl.uop.coef)
         CS_B0:   coef = num_ext[0 +: COEF_WIDTH];
         CS_B1:   coef = num_ext[COEF_WIDTH +: COEF_WIDTH];
         CS_B2:   coef = num_ext[2*COEF_WIDTH +: COEF_WIDTH];
         CS_A1:   coef = den_ext[0 +: COEF_WIDTH];
         CS_A2:   coef = den_ext[COEF_WIDTH +: COEF_WIDTH];
         default: coef = '0;
      endcase
   end

   // Operand and reload value; the running section's delays sit in cur0/cur1
   always_comb begin
      case (ctl.uop.opnd)
         OS_X:    opnd = x_ff;
         OS_T:    opnd = t_ff;
         OS_D0:   opnd = cur0_ff;
         OS_D1:   opnd = cur1_ff;
         default: opnd = x_ff;
      endcase
      init_val = ctl.uop.init_d1 ? cur1_ff : '0;
   end

   // Final scaling: floor shift, then saturate to the sample range
   always_comb begin
      shifted    = x_ff >>> cfg.shift;
      shifted_hi = shifted[STATE_WIDTH-1:SAMPLE_W-1];
      if ((&shifted_hi) || !(|shifted_hi)) begin
         final_val  = shifted[SAMPLE_W-1:0];
         final_clip = 1'b0;
      end else begin
         final_val  = {shifted[STATE_WIDTH-1], {(SAMPLE_W-1){~shifted[STATE_WIDTH-1]}}};
         final_clip = 1'b1;
      end
   end

   // Load x, write back saturated sums, rotate delay pairs at each section end
   always_comb begin
      x_in    = x_ff;
      t_in    = t_ff;
      cur0_in = cur0_ff;
      cur1_in = cur1_ff;
      oth0_in = oth0_ff;
      oth1_in = oth1_ff;
      clip_in = clip_ff;
      if (ctl.load) begin
         x_in    = STATE_WIDTH'(req_bus.sample_in);
         clip_in = 1'b0;
      end
      if (do_sat) begin
         clip_in = clip_ff | sat_clip;
         case (ctl.uop.dest)
            DS_T:  t_in    = sat_val;
            DS_D0: cur0_in = sat_val;
            DS_XSHIFT: begin
               x_in    = sat_val;
               cur0_in = oth0_ff;
               cur1_in = oth1_ff;
               oth0_in = t_ff;
               oth1_in = cur0_ff;
            end
            DS_D1X: begin
               x_in    = t_ff;
               cur0_in = oth0_ff;
               cur1_in = oth1_ff;
               oth0_in = cur0_ff;
               oth1_in = sat_val;
            end
            default: t_in = t_ff;
         endcase
      end
   end

   // Output register: load on finish, drop once taken
   always_comb begin
      out_in       = out_ff;
      outclip_in   = outclip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (ctl.fin) begin
         out_in       = final_val;
         outclip_in   = clip_ff | final_clip;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur0_ff      <= '0;
         cur1_ff      <= '0;
         oth0_ff      <= '0;
         oth1_ff      <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur0_ff      <= cur0_in;
         cur1_ff      <= cur1_in;
         oth0_ff      <= oth0_in;
         oth1_ff      <= oth1_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      t_ff       <= t_in;
      out_ff     <= out_in;
      outclip_ff <= outclip_in;
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("input accepted while an item is still in work");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(ctl.fin))
      else $error("result raised without a finishing step");

   a_no_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      ctl.run |-> !req_bus.ready && !ctl.fin)
      else $error("sequencer running while ready or finishing");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for biquad_cascade_filter: directed and random samples under
// several register settings, with an in-bench fixed-point predictor and a scoreboard.
// Depends on bcf_pkg and the bcf_req_if, bcf_rsp_if and bcf_csr_if interfaces.
module tb_top import bcf_pkg::*;;

   localparam int COEF_W         = COEF_WIDTH_DEF;
   localparam int WORD_W         = STATE_WIDTH_DEF;
   localparam int FRAC_W         = COEF_W - 2;
   localparam int RANDOM_PHASES  = 11;
   localparam int PHASE_ITEMS    = 50;
   localparam int SETTLE_CYCLES  = 24;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   // Indexes the block does not decode; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE1 = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pcm;
      logic                clipped;
   } filt_result_type;

   // Predicts the cascade output per sample and checks results in order
   class cascade_checker;
      cfg_type         regs;
      longint          taps[4];
      bit              clip;
      int              errors;
      int              result_idx;
      filt_result_type expected_outputs[$];

      function void restore_defaults();
         regs.num1  = NUM1_RST;
         regs.den1  = DEN1_RST;
         regs.num2  = NUM2_RST;
         regs.den2  = DEN2_RST;
         regs.tdf   = STRUCT_RST;
         regs.shift = SHIFT_RST;
         foreach (taps[i]) taps[i] = 0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NUM1:   regs.num1  = data[NUM_REG_W-1:0];
            CSR_DEN1:   regs.den1  = data[DEN_REG_W-1:0];
            CSR_NUM2:   regs.num2  = data[NUM_REG_W-1:0];
            CSR_DEN2:   regs.den2  = data[DEN_REG_W-1:0];
            CSR_STRUCT: regs.tdf   = data[0];
            CSR_SHIFT:  regs.shift = data[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint coef_at(logic [NUM_REG_W-1:0] bits, int k);
         logic signed [COEF_W-1:0] c;
         c = bits[k*COEF_W +: COEF_W];
         return longint'(c);
      endfunction

      // Saturate to a signed width and remember that it happened
      function longint clamp(longint v, int w);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            clip = 1'b1;
            return hi;
         end
         if (v < lo) begin
            clip = 1'b1;
            return lo;
         end
         return v;
      endfunction

      // Coefficient times word, rounded half up to the word's fraction
      function longint scale(longint c, longint s);
         return (c * s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      endfunction

      function longint run_biquad(longint x, logic [NUM_REG_W-1:0] num,
                                  logic [NUM_REG_W-1:0] den, int base);
         longint b0, b1, b2, a1, a2, v, y, n0, n1;
         b0 = coef_at(num, 0);
         b1 = coef_at(num, 1);
         b2 = coef_at(num, 2);
         a1 = coef_at(den, 0);
         a2 = coef_at(den, 1);
         if (!regs.tdf) begin
            v = clamp(x - scale(a1, taps[base]) - scale(a2, taps[base+1]), WORD_W);
            y = clamp(scale(b0, v) + scale(b1, taps[base]) + scale(b2, taps[base+1]),
                      WORD_W);
            taps[base+1] = taps[base];
            taps[base]   = v;
         end else begin
            y  = clamp(scale(b0, x) + taps[base], WORD_W);
            n0 = clamp(scale(b1, x) - scale(a1, y) + taps[base+1], WORD_W);
            n1 = clamp(scale(b2, x) - scale(a2, y), WORD_W);
            taps[base]   = n0;
            taps[base+1] = n1;
         end
         return y;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s);
         longint          y;
         filt_result_type e;
         clip = 1'b0;
         y = run_biquad(longint'($signed(s)), regs.num1, {16'd0, regs.den1}, 0);
         y = run_biquad(y, regs.num2, {16'd0, regs.den2}, 2);
         y = clamp(y >>> regs.shift, SAMPLE_W);
         e.pcm     = y[SAMPLE_W-1:0];
         e.clipped = clip;
         expected_outputs.push_back(e);
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [SAMPLE_W-1:0] got_pcm, logic got_clip);
         filt_result_type e;
         result_idx++;
         if (expected_outputs.size() == 0) begin
            report($sformatf("result %0d arrived with none expected", result_idx));
            return;
         end
         e = expected_outputs.pop_front();
         if (got_pcm !== e.pcm)
            report($sformatf("result %0d sample_out got %0d expected %0d", result_idx,
                             $signed(got_pcm), $signed(e.pcm)));
         if (got_clip !== e.clipped)
            report($sformatf("result %0d clipped got %b expected %b", result_idx,
                             got_clip, e.clipped));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcf_req_if req_bus ();
   bcf_rsp_if rsp_bus ();
   bcf_csr_if csr_bus ();

   cascade_checker sb = new();
   bit             no_idle;
   int             results_seen;
   int             rsp_hold_left;
   bit             long_hold_done;
   int             quiet_cycles;

   biquad_cascade_filter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long ones
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      if (r < 3) return 16'($urandom_range(0, 512)) - 16'd256;
      return 16'($urandom());
   endfunction

   function logic [CSR_DATA_W-1:0] rand_word();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_sample(s);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.apply_reg(idx, data);
   endtask

   // Drop valid, wait for every result, then let the sequencer finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stable sections most of the time, arbitrary bit patterns otherwise
   task automatic set_random_config();
      logic [CSR_DATA_W-1:0] num[2];
      logic [CSR_DATA_W-1:0] den[2];
      int                    a1, a2, lim;
      bit                    wild;
      wild = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 2; s++) begin
         if (wild) begin
            num[s] = rand_word();
            den[s] = rand_word();
         end else begin
            num[s] = 48'd0;
            for (int k = 0; k < 3; k++)
               num[s][k*COEF_W +: COEF_W] = 16'($urandom_range(0, 16384)) - 16'd8192;
            a2  = int'($urandom_range(0, 14000)) - 6000;
            lim = 16384 + a2 - 1500;
            a1  = int'($urandom_range(0, 2 * lim)) - lim;
            den[s] = {16'($urandom()), 16'(a2), 16'(a1)};
         end
      end
      if ($urandom_range(0, 3) != 0) write_reg(CSR_NUM1, num[0]);
      if ($urandom_range(0, 3) != 0) write_reg(CSR_DEN1, den[0]);
      if ($urandom_range(0, 3) != 0) write_reg(CSR_NUM2, num[1]);
      if ($urandom_range(0, 3) != 0) write_reg(CSR_DEN2, den[1]);
      if ($urandom_range(0, 4) == 0) write_reg(CSR_SPARE0 + 3'($urandom_range(0, 1)),
                                               rand_word());
      write_reg(CSR_STRUCT, rand_word());
      write_reg(CSR_SHIFT, rand_word());
      csr_bus.valid <= 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            sb.check_result(rsp_bus.sample_out, rsp_bus.clipped);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_hold_left  = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_hold_left = pick_gap();
            rsp_bus.ready <= (rsp_hold_left == 0);
            if (rsp_hold_left > 0) rsp_hold_left--;
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset ||
          (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] dir_a[10];
      logic [SAMPLE_W-1:0] dir_b[6];
      logic [SAMPLE_W-1:0] dir_c[5];
      logic [SAMPLE_W-1:0] dir_d[4];
      dir_a = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
      dir_b = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
      dir_c = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0001};
      dir_d = '{16'h7FFF, 16'h8000, 16'h3039, 16'hFFFF};

      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= '0;
      csr_bus.data      <= '0;
      no_idle = 1'b0;
      sb.restore_defaults();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults, transposed form: zero, full scale, unit steps
      foreach (dir_a[i]) send_sample(dir_a[i]);
      settle();

      // Switch to direct form II with live delay words, no output shift
      write_reg(CSR_STRUCT, 48'd0);
      write_reg(CSR_SHIFT, 48'd0);
      csr_bus.valid <= 1'b0;
      foreach (dir_b[i]) send_sample(dir_b[i]);
      settle();

      // Extreme coefficients, largest shift, upper register bits set
      write_reg(CSR_NUM1, {16'h7FFF, 16'h8000, 16'h7FFF});
      write_reg(CSR_DEN1, {16'hFFFF, 16'h8000, 16'h8000});
      write_reg(CSR_NUM2, {16'h8000, 16'h7FFF, 16'h8000});
      write_reg(CSR_DEN2, {16'hFFFF, 16'h7FFF, 16'h7FFF});
      write_reg(CSR_STRUCT, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_SHIFT, 48'hFFFF_FFFF_FFFF);
      csr_bus.valid <= 1'b0;
      foreach (dir_c[i]) send_sample(dir_c[i]);
      settle();

      // Undecoded indexes, zero feedback, pass-through in direct form
      write_reg(CSR_SPARE0, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_SPARE1, 48'h0000_0000_0000);
      write_reg(CSR_NUM1, 48'h0000_0000_4000);
      write_reg(CSR_DEN1, 48'hABCD_0000_0000);
      write_reg(CSR_NUM2, 48'h0000_0000_4000);
      write_reg(CSR_DEN2, 48'hFFFF_0000_0000);
      write_reg(CSR_STRUCT, 48'hFFFF_FFFF_FFFE);
      write_reg(CSR_SHIFT, 48'd0);
      csr_bus.valid <= 1'b0;
      foreach (dir_d[i]) send_sample(dir_d[i]);

      // Random phases, each under a fresh setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         set_random_config();
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Now and then hold the sender until the block is empty
            if (i > 0 && (($urandom_range(0, 39) == 0) || (ph == 2 && i == 25)))
               settle();
            send_sample(pick_sample());
         end
      end
      no_idle = 1'b0;

      // Drain and close out
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bcf_pkg.sv
hdl/bcf_if.sv
hdl/bcf_csr_regs.sv
hdl/bcf_mac_unit.sv
hdl/bcf_sequencer.sv
hdl/biquad_cascade_filter.sv
verif/tb_top.sv
